>>> rtl/msosc_pkg.sv
package msosc_pkg;

   // Phase accumulator width in 2^-32 turns
   localparam int PHASE_BITS = 32;
   // Sample width, Q1.15
   localparam int SAMPLE_BITS = 16;
   // Quarter-wave address width (default)
   localparam int TABLE_ADDR_BITS = 10;

   // Rotation chain
   localparam int CORDIC_STAGES = 18;
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   // Amplitude is base plus offset, one bit wider than a sample
   localparam int AMP_BITS = SAMPLE_BITS + 1;
   // Product of amplitude and signed sine magnitude
   localparam int PROD_BITS = 2 * AMP_BITS;

   // Configuration register indexes
   localparam logic [1:0] CSR_FREQ_WORD  = 2'd0;
   localparam logic [1:0] CSR_AMP_BASE   = 2'd1;
   localparam logic [1:0] CSR_PHASE_BASE = 2'd2;

   typedef struct packed {
      logic [PHASE_BITS-1:0]  freq_word;
      logic signed [15:0]     amp_base;
      logic [PHASE_BITS-1:0]  phase_base;
   } msosc_cfg_type;

   // One item as it moves down the rotation chain
   typedef struct packed {
      logic                       valid;
      logic signed [CW-1:0]       x;
      logic signed [CW-1:0]       y;
      logic signed [CW-1:0]       z;
      logic                       neg;
      logic signed [AMP_BITS-1:0] amp;
   } msosc_cell_type;

   // Arctangent of 2^-i in 2^-32 turns
   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] a;
      unique case (i)
         0:       a = 32'h20000000;
         1:       a = 32'h12E4051D;
         2:       a = 32'h09FB385B;
         3:       a = 32'h051111D4;
         4:       a = 32'h028B0D43;
         5:       a = 32'h0145D7E1;
         6:       a = 32'h00A2F61E;
         7:       a = 32'h00517C55;
         8:       a = 32'h0028BE53;
         9:       a = 32'h00145F2F;
         10:      a = 32'h000A2F98;
         11:      a = 32'h000517CC;
         12:      a = 32'h00028BE6;
         13:      a = 32'h000145F3;
         14:      a = 32'h0000A2FA;
         15:      a = 32'h0000517D;
         16:      a = 32'h000028BE;
         17:      a = 32'h0000145F;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

>>> rtl/msosc_phase.sv
module msosc_phase import msosc_pkg::*; #(
   parameter int TAB_BITS = TABLE_ADDR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [31:0]            sample_number,
   input  logic signed [15:0]     am_offset,
   input  logic signed [31:0]     pm_offset,
   input  msosc_cfg_type          cfg,
   output msosc_cell_type         cell_out
);

   localparam int ZSHIFT = 29 - TAB_BITS;

   // First stage: frequency product, phase offset, amplitude
   logic                       a_valid_ff;
   logic [PHASE_BITS-1:0]      a_prod_ff, a_prod_in;
   logic [PHASE_BITS-1:0]      a_offs_ff, a_offs_in;
   logic signed [AMP_BITS-1:0] a_amp_ff, a_amp_in;

   always_comb begin
      a_prod_in = sample_number * cfg.freq_word;
      a_offs_in = cfg.phase_base + pm_offset;
      a_amp_in  = {cfg.amp_base[15], cfg.amp_base} + {am_offset[15], am_offset};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         a_prod_ff  <= a_prod_in;
         a_offs_ff  <= a_offs_in;
         a_amp_ff   <= a_amp_in;
      end
   end

   // Second stage: quadrant fold and starting angle of the rotation
   logic [PHASE_BITS-1:0] phase;
   logic [1:0]            quad;
   logic [TAB_BITS-1:0]   idx;
   logic [CW-1:0]         z_start;
   msosc_cell_type        cell_ff, cell_in;

   always_comb begin
      phase = a_prod_ff + a_offs_ff;
      quad  = phase[PHASE_BITS-1 -: 2];
      idx   = phase[PHASE_BITS-3 -: TAB_BITS];
      // odd quadrants run the quarter wave backwards
      if (quad[0]) begin
         idx = ~idx;
      end
      // centre of the step: (2*idx + 1) half steps
      z_start = {{(CW-TAB_BITS-1){1'b0}}, idx, 1'b1} << ZSHIFT;
      cell_in.valid = a_valid_ff;
      cell_in.x     = CORDIC_GAIN;
      cell_in.y     = '0;
      cell_in.z     = z_start;
      cell_in.neg   = quad[1];
      cell_in.amp   = a_amp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/msosc_cell.sv
module msosc_cell import msosc_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  msosc_cell_type cell_in_d,
   output msosc_cell_type cell_out
);

   localparam logic [31:0] ATAN = atan_turns(STAGE);
   localparam logic signed [CW-1:0] ATAN_W = {{(CW-32){1'b0}}, ATAN};

   msosc_cell_type cell_ff, cell_in;
   logic signed [CW-1:0] dx, dy;

   // One micro-rotation, direction from the sign of the residual angle
   always_comb begin
      dx = cell_in_d.y >>> STAGE;
      dy = cell_in_d.x >>> STAGE;
      cell_in = cell_in_d;
      if (!cell_in_d.z[CW-1]) begin
         cell_in.x = cell_in_d.x - dx;
         cell_in.y = cell_in_d.y + dy;
         cell_in.z = cell_in_d.z - ATAN_W;
      end else begin
         cell_in.x = cell_in_d.x + dx;
         cell_in.y = cell_in_d.y - dy;
         cell_in.z = cell_in_d.z + ATAN_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/msosc_post.sv
module msosc_post import msosc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  msosc_cell_type          cell_in_d,
   output logic                    out_valid,
   output logic signed [15:0]      out_sample
);

   localparam int SH = 31 - SAMPLE_BITS;
   localparam logic signed [CW-1:0] Y_HALF = CW'(1) << (SH - 1);
   localparam logic [CW-SH-1:0] MAG_TOP = (CW-SH)'((1 << (SAMPLE_BITS-1)) - 1);
   localparam logic signed [PROD_BITS-1:0] P_HALF = PROD_BITS'(1) << (SAMPLE_BITS - 2);
   localparam logic signed [PROD_BITS-1:0] OUT_MAX = PROD_BITS'(32767);
   localparam logic signed [PROD_BITS-1:0] OUT_MIN = -PROD_BITS'(32768);

   // Magnitude rounding, clamp and quadrant sign
   logic signed [CW-1:0]       y_rnd;
   logic [CW-SH-1:0]           mag_w;
   logic [SAMPLE_BITS-2:0]     mag;
   logic                       c_valid_ff;
   logic signed [AMP_BITS-1:0] c_sine_ff, c_sine_in;
   logic signed [AMP_BITS-1:0] c_amp_ff;

   always_comb begin
      y_rnd = cell_in_d.y + Y_HALF;
      mag_w = y_rnd[CW-1:SH];
      if (cell_in_d.y[CW-1]) begin
         mag = '0;
      end else if (mag_w > MAG_TOP) begin
         mag = MAG_TOP[SAMPLE_BITS-2:0];
      end else begin
         mag = mag_w[SAMPLE_BITS-2:0];
      end
      if (cell_in_d.neg) begin
         c_sine_in = -$signed({2'b00, mag});
      end else begin
         c_sine_in = $signed({2'b00, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= cell_in_d.valid;
         c_sine_ff  <= c_sine_in;
         c_amp_ff   <= cell_in_d.amp;
      end
   end

   // Amplitude times sine
   logic                        d_valid_ff;
   logic signed [PROD_BITS-1:0] d_prod_ff, d_prod_in;

   assign d_prod_in = c_amp_ff * c_sine_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
         d_prod_ff  <= d_prod_in;
      end
   end

   // Round half up and saturate into the output register
   logic signed [PROD_BITS-1:0] p_rnd;
   logic signed [PROD_BITS-1:0] p_sh;
   logic                        out_valid_ff;
   logic signed [15:0]          out_sample_ff, out_sample_in;

   always_comb begin
      p_rnd = d_prod_ff + P_HALF;
      p_sh  = p_rnd >>> (SAMPLE_BITS - 1);
      if (p_sh > OUT_MAX) begin
         out_sample_in = 16'sh7FFF;
      end else if (p_sh < OUT_MIN) begin
         out_sample_in = -16'sh8000;
      end else begin
         out_sample_in = p_sh[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff  <= d_valid_ff;
         out_sample_ff <= out_sample_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = out_sample_ff;

endmodule

>>> rtl/modulated_sine_oscillator.sv
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall sample_number[31:0], am_offset[15:0],
//                                          pm_offset[31:0]
// rsp       out        rsp_valid/rsp_stall sample_out[15:0]
// csr       in         csr_valid/csr_ready csr_index[1:0], csr_wdata[31:0]
//
// One item per cycle while no result is held; an item taken passes through two
// phase stages, one cell per rotation (18), two scaling stages and the output
// register.
// Reset (synchronous) clears all valid bits and the three registers to zero.
// A held result stalls the whole pipe; req_stall follows rsp_valid & rsp_stall.
// Register writes are always taken.
module modulated_sine_oscillator import msosc_pkg::*; #(
   parameter int TAB_BITS = TABLE_ADDR_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_sample_number,
   input  logic signed [15:0]  req_am_offset,
   input  logic signed [31:0]  req_pm_offset,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_sample_out,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   // Configuration registers
   msosc_cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FREQ_WORD:  cfg_ff.freq_word  <= csr_wdata;
            CSR_AMP_BASE:   cfg_ff.amp_base   <= csr_wdata[15:0];
            CSR_PHASE_BASE: cfg_ff.phase_base <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Whole pipe moves unless a finished result is held
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   msosc_cell_type chain [CORDIC_STAGES+1];

   msosc_phase #(
      .TAB_BITS(TAB_BITS)
   ) u_phase (
      .clock         (clock),
      .reset         (reset),
      .en            (advance),
      .in_valid      (req_valid),
      .sample_number (req_sample_number),
      .am_offset     (req_am_offset),
      .pm_offset     (req_pm_offset),
      .cfg           (cfg_ff),
      .cell_out      (chain[0])
   );

   // Rotation chain
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      msosc_cell #(
         .STAGE(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .cell_in_d (chain[i]),
         .cell_out  (chain[i+1])
      );
   end

   msosc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .cell_in_d  (chain[CORDIC_STAGES]),
      .out_valid  (rsp_valid),
      .out_sample (rsp_sample_out)
   );

endmodule

>>> rtl/msosc_checker.sv
module msosc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [15:0]  rsp_sample_out,
   input logic                csr_valid,
   input logic                csr_ready
);

   // A held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("held result changed");

   // Input only stalls behind a held result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // Pipe empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

   // Register writes are never held off
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write held off");

endmodule

bind modulated_sine_oscillator msosc_checker u_msosc_checker (.*);

>>> sim/tb_modulated_sine_oscillator.sv
module tb_modulated_sine_oscillator;
   timeunit 1ns;
   timeprecision 1ps;

   import msosc_pkg::*;

   // Index with no register behind it; writes there are dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int QUARTER_SIZE = 1 << TABLE_ADDR_BITS;
   localparam int ROT_STAGES = 18;
   localparam longint ROT_GAIN = 64'sd652032874;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 190;

   typedef struct packed {
      logic [31:0]        sample_number;
      logic signed [15:0] am_offset;
      logic signed [31:0] pm_offset;
   } osc_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   osc_item_type       cur_item = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // Our copy of the registers
   logic [31:0]        freq_word_q = '0;
   logic signed [15:0] amp_base_q = '0;
   logic [31:0]        phase_base_q = '0;

   // Rotation angles in 2^-32 turns
   logic [31:0] rot_angle [0:ROT_STAGES-1] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F
   };

   int                 sine_mag [0:QUARTER_SIZE-1];
   osc_item_type       item_q [$];
   logic signed [15:0] sample_q [$];
   int                 items_open = 0;
   int                 mismatches = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   bit                 req_taken = 1'b0;

   modulated_sine_oscillator uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_number (cur_item.sample_number),
      .req_am_offset     (cur_item.am_offset),
      .req_pm_offset     (cur_item.pm_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_out    (rsp_sample_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Quarter-wave magnitude at one address, rotated at the step's center
   function automatic int quarter_mag(input int addr);
      longint x, y, z, dx, dy, m;
      x = ROT_GAIN;
      y = 0;
      z = longint'(2 * addr + 1) <<< (29 - TABLE_ADDR_BITS);
      for (int i = 0; i < ROT_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(rot_angle[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(rot_angle[i]);
         end
      end
      if (y < 0)
         return 0;
      m = (y + (64'sd1 <<< 14)) >>> 15;
      if (m > 32767)
         m = 32767;
      return int'(m);
   endfunction

   // Expected output sample for one item under the current registers
   function automatic logic signed [15:0] modulated_sample(input osc_item_type it);
      logic [31:0] phase;
      logic [1:0]  quad;
      logic [TABLE_ADDR_BITS-1:0] addr;
      longint      mag, amp, r;
      phase = it.sample_number * freq_word_q + phase_base_q + it.pm_offset;
      quad = phase[31:30];
      addr = phase[29 -: TABLE_ADDR_BITS];
      if (quad[0])
         addr = ~addr;
      mag = sine_mag[addr];
      if (quad[1])
         mag = -mag;
      amp = longint'(amp_base_q) + longint'(it.am_offset);
      r = (amp * mag + (64'sd1 <<< 14)) >>> 15;
      if (r > 32767)
         r = 32767;
      if (r < -32768)
         r = -32768;
      return r[15:0];
   endfunction

   function automatic osc_item_type random_item();
      osc_item_type it;
      it.sample_number = ($urandom_range(15) == 0) ? 32'hFFFFFFFF : $urandom;
      // Absent modulation sources show up as zero offsets
      case ($urandom_range(5))
         0:       it.am_offset = '0;
         1:       it.am_offset = ($urandom_range(1) == 0) ? 16'sh7FFF : 16'sh8000;
         default: it.am_offset = 16'($urandom);
      endcase
      case ($urandom_range(5))
         0:       it.pm_offset = '0;
         1:       it.pm_offset = ($urandom_range(1) == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: it.pm_offset = $urandom;
      endcase
      return it;
   endfunction

   // Item driver and receiver stalls, on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            req_taken = 1'b0;
            if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_item <= item_q.pop_front();
               req_valid <= 1'b1;
               items_open++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: register writes, accepted items and result checks
   always @(posedge clock) begin : monitor
      logic signed [15:0] want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FREQ_WORD:  freq_word_q = csr_wdata;
               CSR_AMP_BASE:   amp_base_q = csr_wdata[15:0];
               CSR_PHASE_BASE: phase_base_q = csr_wdata;
               default:        ;
            endcase
         end
         if (req_valid && !req_stall) begin
            sample_q.push_back(modulated_sample(cur_item));
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (sample_q.size() == 0) begin
               $error("sample_out: no sample expected, got %0d", rsp_sample_out);
               mismatches++;
            end else begin
               want = sample_q.pop_front();
               items_open--;
               if (rsp_sample_out !== want) begin
                  $error("sample_out: expected %0d, got %0d", want, rsp_sample_out);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic set_regs(input logic [31:0] freq, input logic signed [15:0] amp,
                           input logic [31:0] phase);
      write_reg(CSR_FREQ_WORD, freq);
      write_reg(CSR_AMP_BASE, 32'(amp));
      write_reg(CSR_PHASE_BASE, phase);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every sample sent has come back
   task automatic drain();
      while (item_q.size() != 0 || items_open != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_item(input logic [31:0] sn, input logic signed [15:0] am,
                           input logic signed [31:0] pm);
      osc_item_type it;
      it.sample_number = sn;
      it.am_offset = am;
      it.pm_offset = pm;
      item_q.push_back(it);
   endtask

   // Stimulus
   initial begin
      for (int a = 0; a < QUARTER_SIZE; a++)
         sine_mag[a] = quarter_mag(a);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase set by pm alone: quadrant edges, peak and saturation
      set_regs(32'h0, 16'sh7FFF, 32'h0);
      add_item(32'h0, 16'sh0000, 32'sh00000000);
      add_item(32'h0, 16'sh0000, 32'sh3FF00000);
      add_item(32'h0, 16'sh0000, 32'sh40000000);
      add_item(32'h0, 16'sh0000, 32'sh7FFFFFFF);
      add_item(32'h0, 16'sh0000, 32'sh80000000);
      add_item(32'h0, 16'sh0000, 32'shC0000000);
      add_item(32'h0, 16'sh0000, 32'shFFFFFFFF);
      add_item(32'h0, 16'sh7FFF, 32'sh3FF00000);
      add_item(32'h0, 16'sh7FFF, 32'shBFF00000);
      add_item(32'h0, 16'sh8000, 32'sh3FF00000);
      add_item(32'hFFFFFFFF, 16'sh0000, 32'sh7FFFFFFF);
      drain();

      // Largest registers, most negative amplitude, ignored index
      set_regs(32'hFFFFFFFF, 16'sh8000, 32'hFFFFFFFF);
      write_reg(CSR_UNUSED, 32'h12345678);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      add_item(32'h0, 16'sh0000, 32'sh00000000);
      add_item(32'h0, 16'sh8000, 32'sh3FF00001);
      add_item(32'hFFFFFFFF, 16'sh8000, 32'shC0000000);
      add_item(32'h1, 16'sh7FFF, 32'sh00000000);
      add_item(32'h80000000, 16'sh0001, 32'sh40000000);
      add_item(32'h55555555, 16'sh5555, 32'shAAAAAAAA);
      add_item(32'hAAAAAAAA, 16'shAAAA, 32'sh55555555);
      drain();

      // Tiny amplitudes: rounding of the product in both signs
      set_regs(32'h0, 16'sh0001, 32'h0);
      add_item(32'h0, 16'sh0000, 32'sh3FF00000);
      add_item(32'h0, 16'sh0000, 32'shBFF00000);
      add_item(32'h0, 16'shFFFE, 32'sh3FF00000);
      add_item(32'h0, 16'shFFFE, 32'shBFF00000);
      drain();

      // Random items under a range of settings and idle patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1:       set_regs(32'h0, 16'sh0000, 32'h0);
            2:       set_regs(32'h1, 16'sh7FFF, 32'h80000000);
            3:       set_regs(32'hFFFFFFFF, 16'sh8000, 32'hFFFFFFFF);
            default: set_regs($urandom, 16'($urandom), $urandom);
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            3: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            item_q.push_back(random_item());
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (30) @(posedge clock);
      if (mismatches == 0 && sample_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/msosc_pkg.sv
rtl/msosc_phase.sv
rtl/msosc_cell.sv
rtl/msosc_post.sv
rtl/modulated_sine_oscillator.sv
rtl/msosc_checker.sv
sim/tb_modulated_sine_oscillator.sv
